FILE: src/dmop_pkg.sv
`default_nettype none

package dmop_pkg;

    // Capture limits.
    localparam int MAX_DNS           = 4;
    localparam int HOST_NAME_BYTES   = 16;
    localparam int DOMAIN_NAME_BYTES = 32;
    localparam int SRV_W             = $clog2(MAX_DNS + 1);

    // Queue between the header front end and the option walker.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Magic cookie 99.130.83.99 as it shifts in, first byte on top.
    localparam logic [31:0] COOKIE_WIRE = 32'h6382_5363;

    // Byte offsets within the fixed header.
    localparam logic [8:0] OFS_XID_END      = 9'd7;
    localparam logic [8:0] OFS_YIADDR_END   = 9'd19;
    localparam logic [8:0] OFS_COOKIE_FIRST = 9'd236;
    localparam logic [8:0] OFS_COOKIE_END   = 9'd239;
    localparam logic [8:0] OFS_OPT_START    = 9'd240;

    // Option codes.
    localparam logic [7:0] OPT_PAD     = 8'd0;
    localparam logic [7:0] OPT_MASK    = 8'd1;
    localparam logic [7:0] OPT_ROUTER  = 8'd3;
    localparam logic [7:0] OPT_DNS     = 8'd6;
    localparam logic [7:0] OPT_HOST    = 8'd12;
    localparam logic [7:0] OPT_DOMAIN  = 8'd15;
    localparam logic [7:0] OPT_BCAST   = 8'd28;
    localparam logic [7:0] OPT_LEASE   = 8'd51;
    localparam logic [7:0] OPT_MSGTYPE = 8'd53;
    localparam logic [7:0] OPT_SERVER  = 8'd54;
    localparam logic [7:0] OPT_RENEW   = 8'd58;
    localparam logic [7:0] OPT_REBIND  = 8'd59;
    localparam logic [7:0] OPT_CLIENT  = 8'd61;
    localparam logic [7:0] OPT_END     = 8'd255;

    typedef enum logic [3:0] {
        KIND_XID     = 4'd0,
        KIND_YIADDR  = 4'd1,
        KIND_MSGTYPE = 4'd2,
        KIND_MASK    = 4'd3,
        KIND_ROUTER  = 4'd4,
        KIND_DNS     = 4'd5,
        KIND_HOST    = 4'd6,
        KIND_DOMAIN  = 4'd7,
        KIND_BCAST   = 4'd8,
        KIND_LEASE   = 4'd9,
        KIND_SERVER  = 4'd10,
        KIND_RENEW   = 4'd11,
        KIND_REBIND  = 4'd12,
        KIND_CLIENT  = 4'd13,
        KIND_END     = 4'd14,
        KIND_UNTERM  = 4'd15
    } dmop_kind_t;

    typedef enum logic [1:0] {
        TOK_NONE = 2'd0,
        TOK_REC  = 2'd1,
        TOK_OPT  = 2'd2
    } dmop_tok_kind_t;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } dmop_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } dmop_in_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [55:0] value;
        logic [4:0]  position;
        logic        final_record;
    } dmop_out_t;

    // One queue entry: a finished header record, an option byte, or just
    // a message boundary.
    typedef struct packed {
        dmop_tok_kind_t tok;
        dmop_kind_t     rec_kind;
        logic [31:0]    data;
        logic           last;
    } dmop_tok_t;

    localparam dmop_out_t UNTERM_REC = '{
        kind:         KIND_UNTERM,
        value:        56'd0,
        position:     5'd0,
        final_record: 1'b1
    };

endpackage

`default_nettype wire

FILE: src/dmop_front.sv
`default_nettype none

module dmop_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dmop_pkg::dmop_in_t s_data,
    input  wire logic               q_full,
    output logic                    q_push,
    output dmop_pkg::dmop_tok_t     q_tok
);
    import dmop_pkg::*;

    logic [8:0]  offset_reg, offset_next;
    logic [31:0] hacc_reg, hacc_next;
    logic [31:0] cookie_reg, cookie_next;
    logic        replay_reg, replay_next;
    logic [1:0]  rcnt_reg, rcnt_next;
    logic        rlast_reg, rlast_next;

    logic        s_fire;
    logic [31:0] hacc_shift;
    logic [31:0] cookie_in;
    logic [7:0]  replay_byte;
    logic        start_replay;

    assign s_ready    = !replay_reg && !q_full;
    assign s_fire     = s_valid && s_ready;
    assign hacc_shift = {hacc_reg[23:0], s_data.data_byte};
    assign cookie_in  = {cookie_reg[23:0], s_data.data_byte};

    always_comb begin
        unique case (rcnt_reg)
            2'd1:    replay_byte = cookie_reg[23:16];
            2'd2:    replay_byte = cookie_reg[15:8];
            2'd3:    replay_byte = cookie_reg[7:0];
            default: replay_byte = cookie_reg[31:24];
        endcase
    end

    always_comb begin
        offset_next  = offset_reg;
        hacc_next    = hacc_reg;
        cookie_next  = cookie_reg;
        replay_next  = replay_reg;
        rcnt_next    = rcnt_reg;
        rlast_next   = rlast_reg;
        start_replay = 1'b0;
        q_push       = 1'b0;
        q_tok        = '{tok: TOK_NONE, rec_kind: KIND_XID, data: 32'd0, last: 1'b0};

        if (replay_reg) begin
            // Feed the held cookie bytes to the option walker.
            if (!q_full) begin
                q_push     = 1'b1;
                q_tok.tok  = TOK_OPT;
                q_tok.data = {24'd0, replay_byte};
                q_tok.last = rlast_reg && (rcnt_reg == 2'd3);
                rcnt_next  = rcnt_reg + 2'd1;
                if (rcnt_reg == 2'd3) begin
                    replay_next = 1'b0;
                    if (rlast_reg) begin
                        offset_next = '0;
                    end
                end
            end
        end else if (s_fire) begin
            q_tok.last = s_data.last_byte;
            if (offset_reg < OFS_OPT_START) begin
                hacc_next   = hacc_shift;
                offset_next = offset_reg + 9'd1;
                if (offset_reg >= OFS_COOKIE_FIRST) begin
                    cookie_next = cookie_in;
                end
                if (offset_reg == OFS_XID_END) begin
                    q_tok.tok      = TOK_REC;
                    q_tok.rec_kind = KIND_XID;
                    q_tok.data     = hacc_shift;
                end else if (offset_reg == OFS_YIADDR_END) begin
                    q_tok.tok      = TOK_REC;
                    q_tok.rec_kind = KIND_YIADDR;
                    q_tok.data     = hacc_shift;
                end
                if (offset_reg == OFS_COOKIE_END && cookie_in != COOKIE_WIRE) begin
                    // Bad cookie: its four bytes are really the first options.
                    start_replay = 1'b1;
                    q_tok.tok    = TOK_OPT;
                    q_tok.data   = {24'd0, cookie_in[31:24]};
                    q_tok.last   = 1'b0;
                    replay_next  = 1'b1;
                    rcnt_next    = 2'd1;
                    rlast_next   = s_data.last_byte;
                end
            end else begin
                q_tok.tok  = TOK_OPT;
                q_tok.data = {24'd0, s_data.data_byte};
            end
            q_push = (q_tok.tok != TOK_NONE) || q_tok.last;
            if (s_data.last_byte && !start_replay) begin
                offset_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            replay_reg <= 1'b0;
            rcnt_reg   <= '0;
            rlast_reg  <= 1'b0;
        end else begin
            offset_reg <= offset_next;
            replay_reg <= replay_next;
            rcnt_reg   <= rcnt_next;
            rlast_reg  <= rlast_next;
        end
    end

    always_ff @(posedge aclk) begin
        hacc_reg   <= hacc_next;
        cookie_reg <= cookie_next;
    end

endmodule

`default_nettype wire

FILE: src/dmop_queue.sv
`default_nettype none

module dmop_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire dmop_pkg::dmop_tok_t push_tok,
    input  wire logic                pop,
    output dmop_pkg::dmop_tok_t      pop_tok,
    output logic                     empty,
    output logic                     full
);
    import dmop_pkg::*;

    dmop_tok_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_tok = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_tok;
        end
    end

endmodule

`default_nettype wire

FILE: src/dmop_back.sv
`default_nettype none

module dmop_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_empty,
    input  wire dmop_pkg::dmop_tok_t q_tok,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dmop_pkg::dmop_out_t      m_data
);
    import dmop_pkg::*;

    dmop_phase_t      phase_reg, phase_next, phase_walk;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       idx_reg, idx_next;
    logic [55:0]      acc_reg, acc_next;
    logic [SRV_W-1:0] srv_reg, srv_next;
    logic             ended_reg, ended_next;
    logic             pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;
    dmop_out_t        m_data_reg, m_data_next;

    logic        out_free;
    logic        opt_pop;
    logic [7:0]  b;
    logic [55:0] acc_new;
    logic        rec_valid;
    dmop_out_t   rec;
    logic        word_opt;
    dmop_kind_t  word_kind;
    logic        unterm;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = !q_empty && out_free && !pend_reg;
    assign opt_pop  = q_pop && (q_tok.tok == TOK_OPT);
    assign b        = q_tok.data[7:0];
    assign acc_new  = {acc_reg[47:0], b};
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Option walker phase.
    always_comb begin
        phase_walk = phase_reg;
        if (opt_pop) begin
            unique case (phase_reg)
                PH_CODE: begin
                    if (b == OPT_END) begin
                        phase_walk = PH_DONE;
                    end else if (b != OPT_PAD) begin
                        phase_walk = PH_LEN;
                    end
                end
                PH_LEN:   phase_walk = (b != 8'd0) ? PH_VALUE : PH_CODE;
                PH_VALUE: phase_walk = (left_reg == 8'd1) ? PH_CODE : PH_VALUE;
                PH_DONE:  phase_walk = PH_DONE;
                default:  phase_walk = phase_reg;
            endcase
        end
        phase_next = (q_pop && q_tok.last) ? PH_CODE : phase_walk;
    end

    // Capture datapath and records.
    always_comb begin
        code_next  = code_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        srv_next   = srv_reg;
        ended_next = ended_reg;
        rec_valid  = 1'b0;
        rec        = '0;
        word_opt   = 1'b0;
        word_kind  = KIND_MASK;

        if (q_pop && q_tok.tok == TOK_REC) begin
            rec_valid  = 1'b1;
            rec.kind   = q_tok.rec_kind;
            rec.value  = {24'd0, q_tok.data};
        end

        if (opt_pop) begin
            unique case (phase_reg)
                PH_CODE: begin
                    if (b == OPT_END) begin
                        rec_valid        = 1'b1;
                        rec.kind         = KIND_END;
                        rec.final_record = 1'b1;
                    end else if (b != OPT_PAD) begin
                        code_next = b;
                    end
                end
                PH_LEN: begin
                    left_next  = b;
                    idx_next   = 8'd0;
                    acc_next   = 56'd0;
                    ended_next = 1'b0;
                end
                PH_VALUE: begin
                    acc_next  = acc_new;
                    left_next = left_reg - 8'd1;
                    idx_next  = (idx_reg == 8'hFF) ? idx_reg : idx_reg + 8'd1;
                    unique case (code_reg)
                        OPT_MSGTYPE: begin
                            if (idx_reg == 8'd0) begin
                                rec_valid = 1'b1;
                                rec.kind  = KIND_MSGTYPE;
                                rec.value = {48'd0, b};
                            end
                        end
                        OPT_MASK: begin
                            word_opt  = 1'b1;
                            word_kind = KIND_MASK;
                        end
                        OPT_ROUTER: begin
                            word_opt  = 1'b1;
                            word_kind = KIND_ROUTER;
                        end
                        OPT_BCAST: begin
                            word_opt  = 1'b1;
                            word_kind = KIND_BCAST;
                        end
                        OPT_LEASE: begin
                            word_opt  = 1'b1;
                            word_kind = KIND_LEASE;
                        end
                        OPT_SERVER: begin
                            word_opt  = 1'b1;
                            word_kind = KIND_SERVER;
                        end
                        OPT_RENEW: begin
                            word_opt  = 1'b1;
                            word_kind = KIND_RENEW;
                        end
                        OPT_REBIND: begin
                            word_opt  = 1'b1;
                            word_kind = KIND_REBIND;
                        end
                        OPT_DNS: begin
                            // One address per complete group of four bytes.
                            if (idx_reg[1:0] == 2'b11 && srv_reg < SRV_W'(MAX_DNS)) begin
                                rec_valid    = 1'b1;
                                rec.kind     = KIND_DNS;
                                rec.value    = {24'd0, acc_new[31:0]};
                                rec.position = 5'(srv_reg);
                                srv_next     = srv_reg + SRV_W'(1);
                            end
                        end
                        OPT_HOST: begin
                            if (!ended_reg) begin
                                if (b == 8'd0) begin
                                    ended_next = 1'b1;
                                end else if (idx_reg < 8'(HOST_NAME_BYTES - 1)) begin
                                    rec_valid    = 1'b1;
                                    rec.kind     = KIND_HOST;
                                    rec.value    = {48'd0, b};
                                    rec.position = idx_reg[4:0];
                                end
                            end
                        end
                        OPT_DOMAIN: begin
                            if (!ended_reg) begin
                                if (b == 8'd0) begin
                                    ended_next = 1'b1;
                                end else if (idx_reg < 8'(DOMAIN_NAME_BYTES - 1)) begin
                                    rec_valid    = 1'b1;
                                    rec.kind     = KIND_DOMAIN;
                                    rec.value    = {48'd0, b};
                                    rec.position = idx_reg[4:0];
                                end
                            end
                        end
                        OPT_CLIENT: begin
                            // Only a client id of exactly seven bytes is kept.
                            if (idx_reg == 8'd6 && left_reg == 8'd1) begin
                                rec_valid = 1'b1;
                                rec.kind  = KIND_CLIENT;
                                rec.value = acc_new;
                            end
                        end
                        default: ;
                    endcase
                    if (word_opt && idx_reg == 8'd3) begin
                        rec_valid = 1'b1;
                        rec.kind  = word_kind;
                        rec.value = {24'd0, acc_new[31:0]};
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end

        if (q_pop && q_tok.last) begin
            srv_next = '0;
        end
    end

    // Output register with one extra slot for the closing record.
    always_comb begin
        unterm       = q_pop && q_tok.last && (phase_walk != PH_DONE);
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pend_next    = pend_reg;
        if (out_free) begin
            if (pend_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = UNTERM_REC;
                pend_next    = 1'b0;
            end else if (rec_valid) begin
                m_valid_next = 1'b1;
                m_data_next  = rec;
                pend_next    = unterm;
            end else if (unterm) begin
                m_valid_next = 1'b1;
                m_data_next  = UNTERM_REC;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_CODE;
            srv_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            srv_reg     <= srv_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg   <= code_next;
        left_reg   <= left_next;
        idx_reg    <= idx_next;
        acc_reg    <= acc_next;
        ended_reg  <= ended_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

FILE: src/dhcp_message_option_parser_unit.sv
// DHCP message option parser.
// The s_ channel takes one message byte per word, starting at the op byte,
// with last_byte set on the final byte. The m_ channel delivers one record
// per word: transaction id and offered address from the fixed header, then
// one record per captured option value, and finally exactly one record with
// final_record set (end option, or unterminated if the message ran out).
// A byte accepted on s_ passes through the queue and the output register
// before its record shows on m_. The block takes one byte per cycle while
// s_ready is high. When the magic cookie does not match, its four bytes are
// walked as options, which holds s_ready low during that replay. A byte that
// both yields a record and closes an unterminated message gives two words.
// The front end and the option walker are joined by a four-word queue, so a
// stall on m_ready fills the queue first and only then drops s_ready; no
// word is lost or repeated. Synchronous active-low reset empties the queue
// and output register and returns the parser to the start of a message.
`default_nettype none

module dhcp_message_option_parser_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dmop_pkg::dmop_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dmop_pkg::dmop_out_t     m_data
);
    import dmop_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_empty;
    logic      q_full;
    dmop_tok_t push_tok;
    dmop_tok_t pop_tok;

    // Header counting, cookie check and replay.
    dmop_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_tok   (push_tok)
    );

    dmop_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_tok (push_tok),
        .pop      (q_pop),
        .pop_tok  (pop_tok),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Option walker and output register.
    dmop_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_tok   (pop_tok),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

FILE: src/dmop_checker.sv
`default_nettype none

module dmop_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire dmop_pkg::dmop_out_t m_data
);
    import dmop_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_final_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.final_record ==
            ((m_data.kind == KIND_END) || (m_data.kind == KIND_UNTERM))))
        else $error("final_record does not match closing kind");

    a_close_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.final_record |-> (m_data.value == '0) && (m_data.position == '0))
        else $error("closing record carries data");

    a_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind != KIND_DNS) && (m_data.kind != KIND_HOST)
            && (m_data.kind != KIND_DOMAIN) |-> (m_data.position == '0))
        else $error("position set on a kind without slots");

endmodule

bind dhcp_message_option_parser_unit dmop_checker u_dmop_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
